### rtl/nnscl_pkg.sv
`default_nettype none

package nnscl_pkg;

  localparam int COLOR_W     = 8;
  localparam int SCALE_W     = 4;
  localparam int DIM_W       = 13;
  localparam int COORD_W     = 15;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 13;

  // Reciprocal of the scale in 1.16 fixed point, rounded up. For positions
  // below 4096 the truncated product equals the exact quotient.
  localparam int RECIP_W     = 17;
  localparam int RECIP_SHIFT = 16;

  // Copy counters of the write sequencer cover spans of up to eight.
  localparam int CNT_W = 3;

  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = 2;
  localparam int QCNT_W  = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MODE  = 2'd0,
    REG_SCALE = 2'd1,
    REG_ROWS  = 2'd2,
    REG_COLS  = 2'd3
  } cfg_reg_t;

  // Configuration after clamping to the legal ranges.
  typedef struct packed {
    logic               up;
    logic [SCALE_W-1:0] scale;
    logic [DIM_W-1:0]   rows;
    logic [DIM_W-1:0]   cols;
  } cfg_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } rgb_t;

  // One job for the write sequencer: a span-by-span block of copies.
  typedef struct packed {
    rgb_t               color;
    logic [SCALE_W-1:0] span;
    logic [COORD_W-1:0] base_row;
    logic [COORD_W-1:0] base_col;
  } job_t;

  function automatic logic [RECIP_W-1:0] recip(input logic [SCALE_W-1:0] s);
    logic [RECIP_W-1:0] r;
    unique case (s)
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd5:    r = 17'd13108;
      4'd6:    r = 17'd10923;
      4'd7:    r = 17'd9363;
      4'd8:    r = 17'd8192;
      default: r = 17'd65536;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/nnscl_pix_if.sv
`default_nettype none

interface nnscl_pix_if import nnscl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] red_in;
  logic [COLOR_W-1:0] green_in;
  logic [COLOR_W-1:0] blue_in;

  modport source(output valid, red_in, green_in, blue_in, input ready);
  modport sink(input valid, red_in, green_in, blue_in, output ready);
endinterface

`default_nettype wire

### rtl/nnscl_wr_if.sv
`default_nettype none

interface nnscl_wr_if import nnscl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] red_out;
  logic [COLOR_W-1:0] green_out;
  logic [COLOR_W-1:0] blue_out;
  logic [COORD_W-1:0] out_row;
  logic [COORD_W-1:0] out_col;
  logic               last_copy;

  modport source(output valid, red_out, green_out, blue_out, out_row, out_col, last_copy,
                 input ready);
  modport sink(input valid, red_out, green_out, blue_out, out_row, out_col, last_copy,
               output ready);
endinterface

`default_nettype wire

### rtl/nearest_neighbor_integer_scaler_core.sv
// Nearest-neighbor integer scaler. Pixels of a frame enter in raster order on
// the pix channel, one beat per pixel, and leave as frame-buffer writes on
// the wr channel, each carrying its color and its row and column in the
// output frame. In down mode the top-left pixel of every full scale-by-scale
// block gives one write and all other pixels give none. In up mode every
// pixel gives scale*scale writes, row by row, and the last one is flagged.
// The cfg port sets mode, scale and frame size; write it only while idle.
// A pixel is registered in the front when it is accepted (position and
// reciprocal multiply), is classified there and pushed into the job queue,
// and is then loaded from the queue into the write register. The sequencer
// gives one write per cycle while the receiver is ready: up mode sustains
// one pixel per scale*scale writes, down mode one pixel per cycle. A
// four-entry job queue between front and sequencer lets pixels keep flowing
// while writes are pending or the receiver stalls; when the queue is full
// the front stalls and pix.ready drops. Dropped pixels never wait on the
// queue. Reset clears position, queue and output register and restores
// mode 0, scale 1 and a one-by-one frame.
`default_nettype none

module nearest_neighbor_integer_scaler_core import nnscl_pkg::*; #(
  parameter int MAX_SCALE = 8,
  parameter int MAX_DIM   = 4096
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  nnscl_pix_if.sink                   pix,
  nnscl_wr_if.source                  wr
);

  // Configuration registers as written.
  logic               mode;
  logic [SCALE_W-1:0] scale;
  logic [DIM_W-1:0]   image_rows;
  logic [DIM_W-1:0]   image_cols;

  cfg_t cfg;

  logic push_valid;
  logic push_ready;
  job_t push_job;
  logic job_valid;
  job_t job;
  logic job_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= 1'b0;
      scale      <= SCALE_W'(1);
      image_rows <= DIM_W'(1);
      image_cols <= DIM_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MODE:  mode       <= cfg_data[0];
        REG_SCALE: scale      <= cfg_data[SCALE_W-1:0];
        REG_ROWS:  image_rows <= cfg_data[DIM_W-1:0];
        REG_COLS:  image_cols <= cfg_data[DIM_W-1:0];
      endcase
    end
  end

  // A zero setting acts as one; an oversized one acts as the maximum.
  always_comb begin
    cfg.up = mode;
    if (scale == '0) begin
      cfg.scale = SCALE_W'(1);
    end else if (scale > SCALE_W'(MAX_SCALE)) begin
      cfg.scale = SCALE_W'(MAX_SCALE);
    end else begin
      cfg.scale = scale;
    end
    if (image_rows == '0) begin
      cfg.rows = DIM_W'(1);
    end else if (image_rows > DIM_W'(MAX_DIM)) begin
      cfg.rows = DIM_W'(MAX_DIM);
    end else begin
      cfg.rows = image_rows;
    end
    if (image_cols == '0) begin
      cfg.cols = DIM_W'(1);
    end else if (image_cols > DIM_W'(MAX_DIM)) begin
      cfg.cols = DIM_W'(MAX_DIM);
    end else begin
      cfg.cols = image_cols;
    end
  end

  nnscl_front #(
    .MAX_DIM(MAX_DIM)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pix       (pix),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_job  (push_job)
  );

  nnscl_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_job  (push_job),
    .pop_valid (job_valid),
    .pop_ready (job_pop),
    .pop_job   (job)
  );

  nnscl_back u_back (
    .clk      (clk),
    .rst      (rst),
    .job_valid(job_valid),
    .job      (job),
    .job_pop  (job_pop),
    .wr       (wr)
  );

  // Retiring a job always leaves its last write in the output register.
  a_pop_leaves_beat: assert property (@(posedge clk) disable iff (rst)
    job_pop |=> wr.valid)
    else $error("job retired without a pending write beat");

  // A copy that is not the last of its pixel is followed at once by the next.
  a_copies_contiguous: assert property (@(posedge clk) disable iff (rst)
    wr.valid && wr.ready && !wr.last_copy |=> wr.valid)
    else $error("gap inside the copies of one pixel");

  // A classified pixel that could not be queued is held, not lost.
  a_front_holds: assert property (@(posedge clk) disable iff (rst)
    push_valid && !push_ready |=> push_valid)
    else $error("front lost a job while the queue was full");

  // Reset leaves no job queued and no write pending.
  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !wr.valid && !job_valid)
    else $error("state left over after reset");

endmodule

`default_nettype wire

### rtl/nnscl_front.sv
`default_nettype none

module nnscl_front import nnscl_pkg::*; #(
  parameter int MAX_DIM = 4096
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire cfg_t    cfg,
  nnscl_pix_if.sink    pix,
  output logic         push_valid,
  input  wire logic    push_ready,
  output job_t         push_job
);

  localparam int PW = $clog2(MAX_DIM);
  localparam int DW = PW + 1;
  localparam int MW = PW + RECIP_W;
  localparam int SW = PW + SCALE_W;

  logic [PW-1:0] row_pos;
  logic [PW-1:0] col_pos;
  logic [PW-1:0] row_pos_next;
  logic [PW-1:0] col_pos_next;

  logic [DW-1:0]      rows;
  logic [DW-1:0]      cols;
  logic [SCALE_W-1:0] s;
  logic [RECIP_W-1:0] rcp;
  logic [MW-1:0]      row_prod;
  logic [MW-1:0]      col_prod;
  logic [SW-1:0]      row_mul;
  logic [SW-1:0]      col_mul;
  logic               fit;
  logic               accept;
  logic               advance;

  // Stage 1 registers.
  logic               s1_valid;
  rgb_t               s1_color;
  logic               s1_up;
  logic [SCALE_W-1:0] s1_s;
  logic [PW-1:0]      s1_row;
  logic [PW-1:0]      s1_col;
  logic [PW-1:0]      s1_row_q;
  logic [PW-1:0]      s1_col_q;
  logic [COORD_W-1:0] s1_row_up;
  logic [COORD_W-1:0] s1_col_up;
  logic               s1_fit;

  logic [SW-1:0] row_chk;
  logic [SW-1:0] col_chk;
  logic          top_left;
  logic          keep;

  assign rows = cfg.rows[DW-1:0];
  assign cols = cfg.cols[DW-1:0];
  assign s    = cfg.scale;
  assign rcp  = recip(s);

  always_comb begin
    row_pos_next = row_pos;
    col_pos_next = PW'(col_pos + PW'(1));
    if ((DW'(col_pos) + DW'(1)) >= cols) begin
      col_pos_next = '0;
      if ((DW'(row_pos) + DW'(1)) >= rows) begin
        row_pos_next = '0;
      end else begin
        row_pos_next = PW'(row_pos + PW'(1));
      end
    end
  end

  assign row_prod = MW'(row_pos) * MW'(rcp);
  assign col_prod = MW'(col_pos) * MW'(rcp);
  assign row_mul  = SW'(row_pos) * SW'(s);
  assign col_mul  = SW'(col_pos) * SW'(s);
  // Only meaningful for a block's top-left pixel: the block lies fully inside.
  assign fit = ((DW + 1)'(row_pos) + (DW + 1)'(s) <= (DW + 1)'(rows)) &&
               ((DW + 1)'(col_pos) + (DW + 1)'(s) <= (DW + 1)'(cols));

  assign row_chk  = SW'(s1_row_q) * SW'(s1_s);
  assign col_chk  = SW'(s1_col_q) * SW'(s1_s);
  assign top_left = (row_chk == SW'(s1_row)) && (col_chk == SW'(s1_col));
  assign keep     = s1_up || (top_left && s1_fit);

  assign advance   = !s1_valid || !keep || push_ready;
  assign pix.ready = advance;
  assign accept    = pix.valid && advance;

  assign push_valid              = s1_valid && keep;
  assign push_job.color          = s1_color;
  assign push_job.span           = s1_up ? s1_s : SCALE_W'(1);
  assign push_job.base_row       = s1_up ? s1_row_up : COORD_W'(s1_row_q);
  assign push_job.base_col       = s1_up ? s1_col_up : COORD_W'(s1_col_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      row_pos  <= '0;
      col_pos  <= '0;
    end else begin
      if (advance) begin
        s1_valid <= pix.valid;
      end
      if (accept) begin
        row_pos <= row_pos_next;
        col_pos <= col_pos_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_color.red   <= pix.red_in;
      s1_color.green <= pix.green_in;
      s1_color.blue  <= pix.blue_in;
      s1_up          <= cfg.up;
      s1_s           <= s;
      s1_row         <= row_pos;
      s1_col         <= col_pos;
      s1_row_q       <= row_prod[PW+RECIP_SHIFT-1:RECIP_SHIFT];
      s1_col_q       <= col_prod[PW+RECIP_SHIFT-1:RECIP_SHIFT];
      s1_row_up      <= COORD_W'(row_mul);
      s1_col_up      <= COORD_W'(col_mul);
      s1_fit         <= fit;
    end
  end

endmodule

`default_nettype wire

### rtl/nnscl_queue.sv
`default_nettype none

module nnscl_queue import nnscl_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push_valid,
  output logic      push_ready,
  input  wire job_t push_job,
  output logic      pop_valid,
  input  wire logic pop_ready,
  output job_t      pop_job
);

  job_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  assign push_ready = count != QCNT_W'(QDEPTH);
  assign pop_valid  = count != '0;
  assign pop_job    = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= QPTR_W'(wr_ptr + QPTR_W'(1));
      end
      if (pop) begin
        rd_ptr <= QPTR_W'(rd_ptr + QPTR_W'(1));
      end
      if (push && !pop) begin
        count <= QCNT_W'(count + QCNT_W'(1));
      end else if (pop && !push) begin
        count <= QCNT_W'(count - QCNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

`default_nettype wire

### rtl/nnscl_back.sv
`default_nettype none

module nnscl_back import nnscl_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic job_valid,
  input  wire job_t job,
  output logic      job_pop,
  nnscl_wr_if.source wr
);

  logic [CNT_W-1:0]   u;
  logic [CNT_W-1:0]   v;
  logic               load;
  logic               u_last;
  logic               v_last;
  logic               out_valid;
  rgb_t               out_color;
  logic [COORD_W-1:0] out_row;
  logic [COORD_W-1:0] out_col;
  logic               out_last;

  assign load    = job_valid && (!out_valid || wr.ready);
  assign v_last  = (SCALE_W'(v) + SCALE_W'(1)) == job.span;
  assign u_last  = (SCALE_W'(u) + SCALE_W'(1)) == job.span;
  assign job_pop = load && u_last && v_last;

  assign wr.valid     = out_valid;
  assign wr.red_out   = out_color.red;
  assign wr.green_out = out_color.green;
  assign wr.blue_out  = out_color.blue;
  assign wr.out_row   = out_row;
  assign wr.out_col   = out_col;
  assign wr.last_copy = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      u         <= '0;
      v         <= '0;
    end else begin
      out_valid <= load || (out_valid && !wr.ready);
      if (load) begin
        if (v_last) begin
          v <= '0;
          u <= u_last ? '0 : CNT_W'(u + CNT_W'(1));
        end else begin
          v <= CNT_W'(v + CNT_W'(1));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_color <= job.color;
      out_row   <= COORD_W'(job.base_row + COORD_W'(u));
      out_col   <= COORD_W'(job.base_col + COORD_W'(v));
      out_last  <= u_last && v_last;
    end
  end

endmodule

`default_nettype wire

### test/nnscl_scaler_checker.sv
`default_nettype none

module nnscl_scaler_checker import nnscl_pkg::*; #(
  parameter int MAX_SCALE = 8,
  parameter int MAX_DIM   = 4096
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  nnscl_pix_if                        pix,
  nnscl_wr_if                         wr,
  output int                          fail_count,
  output int                          pending
);

  localparam int POS_W = 12;

  typedef struct packed {
    rgb_t               color;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               last;
  } fb_write_t;

  fb_write_t pending_writes[$];

  logic               mode_up;
  logic [SCALE_W-1:0] scale_reg;
  logic [DIM_W-1:0]   rows_reg;
  logic [DIM_W-1:0]   cols_reg;
  logic [POS_W-1:0]   row_pos;
  logic [POS_W-1:0]   col_pos;
  int                 errors = 0;

  function automatic int unsigned clamp_to(input int unsigned v, input int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Works out the frame-buffer writes that one pixel causes at the current
  // raster position, then moves the position on.
  task automatic queue_pixel_writes(input rgb_t color);
    int unsigned s;
    int unsigned nrows;
    int unsigned ncols;
    int unsigned r;
    int unsigned c;
    fb_write_t   w;
    s     = clamp_to(scale_reg, MAX_SCALE);
    nrows = clamp_to(rows_reg, MAX_DIM);
    ncols = clamp_to(cols_reg, MAX_DIM);
    r     = row_pos;
    c     = col_pos;
    w.color = color;
    if (!mode_up) begin
      if ((r % s == 0) && (c % s == 0) && (r / s < nrows / s) && (c / s < ncols / s)) begin
        w.row  = COORD_W'(r / s);
        w.col  = COORD_W'(c / s);
        w.last = 1'b1;
        pending_writes.push_back(w);
      end
    end else begin
      for (int unsigned u = 0; u < s; u++) begin
        for (int unsigned v = 0; v < s; v++) begin
          w.row  = COORD_W'(r * s + u);
          w.col  = COORD_W'(c * s + v);
          w.last = (u + 1 == s) && (v + 1 == s);
          pending_writes.push_back(w);
        end
      end
    end
    if (c + 1 >= ncols) begin
      col_pos = '0;
      if (r + 1 >= nrows) row_pos = '0;
      else row_pos = POS_W'(r + 1);
    end else begin
      col_pos = POS_W'(c + 1);
    end
  endtask

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: write %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      errors++;
    end
  endtask

  task automatic check_write();
    fb_write_t want;
    if (pending_writes.size() == 0) begin
      $display("%0t: unexpected write, expected none, actual row %0d col %0d", $time,
               wr.out_row, wr.out_col);
      errors++;
    end else begin
      want = pending_writes.pop_front();
      check_field("red", want.color.red, wr.red_out);
      check_field("green", want.color.green, wr.green_out);
      check_field("blue", want.color.blue, wr.blue_out);
      check_field("out_row", want.row, wr.out_row);
      check_field("out_col", want.col, wr.out_col);
      check_field("last_copy", want.last, wr.last_copy);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      mode_up   = 1'b0;
      scale_reg = SCALE_W'(1);
      rows_reg  = DIM_W'(1);
      cols_reg  = DIM_W'(1);
      row_pos   = '0;
      col_pos   = '0;
      pending_writes.delete();
    end else begin
      // A write beat never belongs to a pixel taken at the same edge, so the
      // comparison goes first.
      if (wr.valid && wr.ready) check_write();
      if (pix.valid && pix.ready) begin
        queue_pixel_writes(rgb_t'({pix.red_in, pix.green_in, pix.blue_in}));
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_MODE:  mode_up   = cfg_data[0];
          REG_SCALE: scale_reg = cfg_data[SCALE_W-1:0];
          REG_ROWS:  rows_reg  = cfg_data[DIM_W-1:0];
          REG_COLS:  cols_reg  = cfg_data[DIM_W-1:0];
          default: ;
        endcase
      end
    end
    fail_count <= errors;
    pending    <= pending_writes.size();
  end

endmodule

`default_nettype wire

### test/tb_nearest_neighbor_integer_scaler_core.sv
`default_nettype none

module tb_nearest_neighbor_integer_scaler_core;
  import nnscl_pkg::*;

  // The run is bounded by a plain cycle counter. The slowest correct run is
  // dominated by up-mode pixels at scale eight (64 write beats each) under a
  // stalling receiver; a little over a hundred pixels stay far below this.
  localparam int CYCLE_LIMIT  = 200000;
  // A dropped pixel leaves no trace on the write channel. Waiting this many
  // cycles after the last expected beat lets any such pixel leave the front.
  localparam int DRAIN_CYCLES = 16;
  localparam int IDLE_PCT     = 37;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  nnscl_pix_if pix ();
  nnscl_wr_if  wr ();

  int   fail_count;
  int   pending;
  logic quiet;
  int   cycle_count = 0;

  // Raw register values as last written, used only to size the frames that
  // the random part sends.
  int cur_rows;
  int cur_cols;

  int random_pixels;
  int phase;
  int frame_px;
  int count;

  nearest_neighbor_integer_scaler_core #(
    .MAX_SCALE(8),
    .MAX_DIM  (4096)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .pix      (pix),
    .wr       (wr)
  );

  // The checker watches both channels and the register port, keeps its own
  // copy of the scaler state and compares every write beat.
  nnscl_scaler_checker #(
    .MAX_SCALE(8),
    .MAX_DIM  (4096)
  ) i_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix       (pix),
    .wr        (wr),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The frame buffer side stalls at random, except during quiet stretches.
  always @(posedge clk) begin
    wr.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int clamp_dim(input int v);
    if (v == 0) return 1;
    if (v > 4096) return 4096;
    return v;
  endfunction

  // Scale values: mostly small, sometimes zero, eight, or above the maximum.
  // The unused upper bits of the data word carry random junk.
  function automatic logic [CFG_DATA_W-1:0] pick_scale();
    logic [CFG_DATA_W-1:0] value;
    int unsigned           k;
    value = CFG_DATA_W'($urandom);
    k     = $urandom_range(9);
    if (k == 0) value[SCALE_W-1:0] = '0;
    else if (k == 1) value[SCALE_W-1:0] = SCALE_W'(8);
    else if (k == 2) value[SCALE_W-1:0] = SCALE_W'($urandom_range(15, 9));
    else value[SCALE_W-1:0] = SCALE_W'($urandom_range(4, 1));
    return value;
  endfunction

  // Frame dimensions: mostly small frames so that whole frames go through,
  // sometimes zero, the maximum, or beyond it.
  function automatic logic [CFG_DATA_W-1:0] pick_dim();
    int unsigned k;
    k = $urandom_range(9);
    if (k == 0) return '0;
    if (k == 1) return CFG_DATA_W'(4096);
    if (k == 2) return CFG_DATA_W'($urandom_range(8191, 4097));
    return CFG_DATA_W'($urandom_range(12, 1));
  endfunction

  function automatic rgb_t random_rgb();
    return rgb_t'(24'($urandom));
  endfunction

  // One register write, followed by a pause with the write enable low so
  // that back-to-back writes never assign cfg_we twice in one step.
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_ROWS) cur_rows = value;
    if (idx == REG_COLS) cur_cols = value;
  endtask

  // Offers one pixel beat and returns at the edge where it is taken. A gap,
  // if any, lowers valid at the step of the previous acceptance; without a
  // gap valid simply stays high for the next beat.
  task automatic send_pixel(input rgb_t color);
    int gap;
    gap = 0;
    if (!quiet) begin
      while ($urandom_range(99) < IDLE_PCT) gap++;
    end
    if (gap > 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix.valid    <= 1'b1;
    pix.red_in   <= color.red;
    pix.green_in <= color.green;
    pix.blue_in  <= color.blue;
    do @(posedge clk); while (!pix.ready);
  endtask

  // The sender holds off until every expected write beat has arrived, then
  // waits out the front latency so a dropped pixel has surely left too.
  // Registers are only written after this.
  task automatic settle();
    pix.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= REG_MODE;
    cfg_data  <= '0;
    pix.valid    <= 1'b0;
    pix.red_in   <= '0;
    pix.green_in <= '0;
    pix.blue_in  <= '0;
    quiet     <= 1'b0;
    cur_rows  = 1;
    cur_cols  = 1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // After reset the block is in down mode at scale one with a one-by-one
    // frame, so every pixel becomes a single write at the origin.
    send_pixel(rgb_t'({8'h00, 8'h00, 8'h00}));
    send_pixel(rgb_t'({8'hFF, 8'hFF, 8'hFF}));
    settle();

    // Up mode at the largest scale over a two-by-two frame. The mode word
    // has all its upper bits set, which must be ignored.
    write_reg(REG_MODE, CFG_DATA_W'(13'h1FFF));
    write_reg(REG_SCALE, CFG_DATA_W'(8));
    write_reg(REG_ROWS, CFG_DATA_W'(2));
    write_reg(REG_COLS, CFG_DATA_W'(2));
    send_pixel(rgb_t'({8'hFF, 8'h00, 8'hAA}));
    send_pixel(rgb_t'({8'h00, 8'hFF, 8'h55}));
    send_pixel(rgb_t'({8'hAA, 8'h55, 8'hFF}));
    send_pixel(rgb_t'({8'h55, 8'hAA, 8'h00}));
    settle();

    // A zero scale and zero dimensions behave as one.
    write_reg(REG_SCALE, '0);
    write_reg(REG_ROWS, '0);
    write_reg(REG_COLS, '0);
    send_pixel(random_rgb());
    send_pixel(random_rgb());
    settle();

    // Scale and dimensions above their maxima are clamped to the maxima.
    write_reg(REG_SCALE, CFG_DATA_W'(13'h1FFF));
    write_reg(REG_ROWS, CFG_DATA_W'(8191));
    write_reg(REG_COLS, CFG_DATA_W'(4097));
    send_pixel(random_rgb());
    send_pixel(random_rgb());
    settle();

    // Down mode at scale three over a seven-by-seven frame: most pixels are
    // dropped, and those of the partial edge blocks are dropped as well.
    write_reg(REG_MODE, '0);
    write_reg(REG_SCALE, CFG_DATA_W'(3));
    write_reg(REG_ROWS, CFG_DATA_W'(7));
    write_reg(REG_COLS, CFG_DATA_W'(7));
    repeat (7) send_pixel(random_rgb());
    settle();

    // Move the column past two, then shrink the frame to two columns. The
    // next pixel sits outside the frame: up mode still replicates it there.
    write_reg(REG_SCALE, CFG_DATA_W'(1));
    write_reg(REG_ROWS, CFG_DATA_W'(4096));
    write_reg(REG_COLS, CFG_DATA_W'(4096));
    repeat (3) send_pixel(random_rgb());
    settle();
    write_reg(REG_COLS, CFG_DATA_W'(2));
    write_reg(REG_MODE, CFG_DATA_W'(1));
    write_reg(REG_SCALE, CFG_DATA_W'(2));
    send_pixel(random_rgb());
    settle();

    // The same situation in down mode, where such a pixel is dropped.
    write_reg(REG_MODE, '0);
    write_reg(REG_COLS, CFG_DATA_W'(4096));
    repeat (3) send_pixel(random_rgb());
    settle();
    write_reg(REG_COLS, CFG_DATA_W'(2));
    send_pixel(random_rgb());
    settle();

    // A long stretch with no idling on either side. A one-by-one frame first
    // brings the position back to the origin, then a whole four-by-five
    // frame goes through in up mode at scale three.
    quiet <= 1'b1;
    write_reg(REG_ROWS, CFG_DATA_W'(1));
    write_reg(REG_COLS, CFG_DATA_W'(1));
    write_reg(REG_SCALE, CFG_DATA_W'(1));
    send_pixel(random_rgb());
    settle();
    write_reg(REG_MODE, CFG_DATA_W'(1));
    write_reg(REG_SCALE, CFG_DATA_W'(3));
    write_reg(REG_ROWS, CFG_DATA_W'(4));
    write_reg(REG_COLS, CFG_DATA_W'(5));
    repeat (20) send_pixel(random_rgb());
    settle();

    // Random phases. Each one rewrites some of the registers while idle, so
    // the position may carry over from the previous frame shape. Small
    // frames are mostly sent whole, so frames wrap and restart. The fourth
    // phase runs with no idling, and some pause midway until all writes are
    // in.
    random_pixels = 0;
    phase         = 0;
    while (random_pixels < 55 || phase < 4) begin
      settle();
      quiet <= (phase == 3);
      if ($urandom_range(3) != 0) write_reg(REG_MODE, CFG_DATA_W'($urandom));
      if ($urandom_range(3) != 0) write_reg(REG_SCALE, pick_scale());
      if ($urandom_range(3) != 0) write_reg(REG_ROWS, pick_dim());
      if ($urandom_range(3) != 0) write_reg(REG_COLS, pick_dim());
      frame_px = clamp_dim(cur_rows) * clamp_dim(cur_cols);
      if (frame_px <= 48 && $urandom_range(9) < 7) count = frame_px;
      else count = $urandom_range(20, 4);
      for (int i = 0; i < count; i++) begin
        send_pixel(random_rgb());
        if (i == count / 2 && $urandom_range(3) == 0) settle();
      end
      random_pixels += count;
      phase++;
    end

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
